### design/crc_checked_register_read_link_macros.svh
// Assertion macros shared by the link design.
`ifndef CRC_CHECKED_REGISTER_READ_LINK_MACROS_SVH
`define CRC_CHECKED_REGISTER_READ_LINK_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/crl_pkg.sv
// ----------------------------------------------------------------------------
// crl_pkg
// Types, constants and CRC helpers for the register read link.
// ----------------------------------------------------------------------------
package crl_pkg;

    localparam int DATA_DEPTH = 256;
    localparam int DATA_AW    = $clog2(DATA_DEPTH);

    localparam logic [7:0] SYNC_BYTE   = 8'h69;
    localparam logic [7:0] HDR_CTRL    = 8'h84;
    localparam logic [7:0] HDR_LEN     = 8'h0C;
    localparam logic [7:0] SOFT_CTRL   = 8'h80;
    localparam logic [15:0] TIMEOUT_RST = 16'd500;
    localparam logic [7:0] FUNC_RST    = 8'h40;
    localparam logic [8:0] REQ_LEN     = 9'd20;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HDR_CRC = 3'd1,
        ST_LENGTH  = 3'd2,
        ST_PAY_CRC = 3'd3,
        ST_TIMEOUT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_TARGET  = 2'd0,
        REG_SOURCE  = 2'd1,
        REG_FUNC    = 2'd2,
        REG_TIMEOUT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [2:0]  status;
        logic [15:0] word_value;
        logic        word_valid;
        logic        last;
    } result_t;

    // Memory write request from the frame checker.
    typedef struct packed {
        logic               en;
        logic [DATA_AW-1:0] addr;
        logic [7:0]         data;
    } mem_wr_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
            c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
        return c;
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

endpackage

### design/crl_if.sv
// ----------------------------------------------------------------------------
// crl_if
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------
interface crl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] start_register;
    logic [7:0]  count;
    logic [7:0]  rx_byte;
    logic [15:0] register_addr;
    modport source (output valid, command, start_register, count, rx_byte, register_addr,
                    input ready);
    modport sink (input valid, command, start_register, count, rx_byte, register_addr,
                  output ready);
endinterface

interface crl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [2:0]  status;
    logic [15:0] word_value;
    logic        word_valid;
    logic        last;
    modport source (output valid, kind, tx_byte, status, word_value, word_valid, last,
                    input ready);
    modport sink (input valid, kind, tx_byte, status, word_value, word_valid, last,
                  output ready);
endinterface

interface crl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/crl_data_ram.sv
// ----------------------------------------------------------------------------
// crl_data_ram
// Frame data store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module crl_data_ram
(
    input  logic               clk,
    input  crl_pkg::mem_wr_t   wr,
    input  logic [crl_pkg::DATA_AW-1:0] rd_addr_a,
    input  logic [crl_pkg::DATA_AW-1:0] rd_addr_b,
    output logic [7:0]         rd_data_a,
    output logic [7:0]         rd_data_b
);
    import crl_pkg::*;

    logic [7:0] mem [DATA_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end
endmodule

### design/crl_req_gen.sv
// ----------------------------------------------------------------------------
// crl_req_gen
// Builds the 20-byte read request one byte per call index; CRCs run as the
// bytes go out.
// ----------------------------------------------------------------------------
module crl_req_gen
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,       // load a new request
    input  logic         advance,     // current byte taken
    input  logic [7:0]   target,
    input  logic [7:0]   source,
    input  logic [7:0]   func,
    input  logic [7:0]   count,
    input  logic [15:0]  start_register,
    output logic         busy,
    output logic [7:0]   tx_byte,
    output logic         tx_last
);
    import crl_pkg::*;

    logic [4:0]  idx_reg, idx_next;
    logic        busy_reg, busy_next;
    logic [7:0]  crc8_reg, crc8_next;
    logic [15:0] crc16_reg, crc16_next;
    logic [7:0]  cnt_reg;
    logic [15:0] sreg_reg;
    logic [7:0]  tgt_reg, src_reg, fn_reg;

    always_comb
    begin
        case (idx_reg)
            5'd0:  tx_byte = SYNC_BYTE;
            5'd1:  tx_byte = tgt_reg;
            5'd2:  tx_byte = src_reg;
            5'd3:  tx_byte = HDR_CTRL;
            5'd6:  tx_byte = HDR_LEN;
            5'd7:  tx_byte = crc8_reg;
            5'd8:  tx_byte = tgt_reg;
            5'd10: tx_byte = src_reg;
            5'd12: tx_byte = fn_reg;
            5'd13: tx_byte = SOFT_CTRL;
            5'd15: tx_byte = cnt_reg;
            5'd16: tx_byte = sreg_reg[7:0];
            5'd17: tx_byte = sreg_reg[15:8];
            5'd18: tx_byte = crc16_reg[15:8];
            5'd19: tx_byte = crc16_reg[7:0];
            default: tx_byte = 8'h00;
        endcase
    end

    assign busy    = busy_reg;
    assign tx_last = (idx_reg == 5'd19);

    always_comb
    begin
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        crc8_next  = crc8_reg;
        crc16_next = crc16_reg;
        if (start)
        begin
            idx_next   = '0;
            busy_next  = 1'b1;
            crc8_next  = '0;
            crc16_next = '0;
        end
        else if (advance && busy_reg)
        begin
            if (idx_reg < 5'd7)
                crc8_next = crc8_step(crc8_reg, tx_byte);
            if (idx_reg >= 5'd8 && idx_reg < 5'd18)
                crc16_next = crc16_step(crc16_reg, tx_byte);
            idx_next  = idx_reg + 5'd1;
            if (tx_last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc8_reg  <= crc8_next;
        crc16_reg <= crc16_next;
        if (start)
        begin
            cnt_reg  <= count;
            sreg_reg <= start_register;
            tgt_reg  <= target;
            src_reg  <= source;
            fn_reg   <= func;
        end
    end
endmodule

### design/crc_checked_register_read_link.sv
// ----------------------------------------------------------------------------
// crc_checked_register_read_link
// Serial register read link: request builder, frame checker, word reads.
// ----------------------------------------------------------------------------
// A start item makes the block send a 20-byte read request as 20 transfers
// of kind 0, one per cycle while the sink keeps up (the request generator
// steps one byte a cycle); no other item is taken while the request streams
// out. Received bytes and ticks are taken one per cycle while no request
// streams, no read answer waits and the output queue has room. Bytes from
// the sync 0x69 on update the header CRC-8 and payload CRC-16, and data
// bytes are written to the 256-byte data RAM; completing the frame yields
// one status transfer. A read item yields one answer transfer: the RAM is
// read at both byte addresses in the accept cycle and the word is formed
// from the registered read data. The input is held off for the cycle after
// a read while its answer is queued, so a new item is not taken before the
// answer is queued. The output has a two-entry queue so a stalled sink does
// not stop input acceptance until it fills. The data RAM has no reset.
// ----------------------------------------------------------------------------
module crc_checked_register_read_link
(
    input  logic clk,
    input  logic rst_n,
    crl_in_if.sink    in_ch,
    crl_out_if.source out_ch,
    crl_cfg_if.sink   cfg
);
    import crl_pkg::*;
`include "crc_checked_register_read_link_macros.svh"

    // configuration registers
    logic [7:0]  target_reg, source_reg, func_reg;
    logic [15:0] timeout_reg;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '0;
            source_reg  <= '0;
            func_reg    <= FUNC_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_TARGET:  target_reg  <= cfg.data[7:0];
                REG_SOURCE:  source_reg  <= cfg.data[7:0];
                REG_FUNC:    func_reg    <= cfg.data[7:0];
                REG_TIMEOUT: timeout_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // frame state
    logic        awaiting_reg;
    logic [8:0]  pos_reg, exp_len_reg;
    logic [15:0] tick_reg;
    logic [7:0]  hcrc_reg, plen_reg, fdlen_reg;
    logic        hcrc_ok_reg, dvalid_reg;
    logic [15:0] pcrc_reg, rcrc_reg, fstart_reg;

    // output queue (two entries)
    result_t q_reg [2];
    logic [1:0] q_cnt_reg;
    logic       q_rd_reg, q_wr_reg;

    // request generator
    logic       rg_busy, rg_last;
    logic [7:0] rg_byte;
    logic       rg_adv;

    // pipeline stage for read answers
    logic        rd_pend_reg, rd_ok_reg;

    logic        accept;
    logic        push;
    result_t     push_res;
    logic        pop;
    mem_wr_t     wr;
    logic [7:0]  ra_data, rb_data;
    logic [15:0] off;
    logic [8:0]  have;
    logic        rd_ok;
    logic        is_start, is_byte, is_tick, is_read;

    assign pop    = out_ch.valid && out_ch.ready;

    // no new item while a read answer still has to be queued
    assign in_ch.ready = !rg_busy && !rd_pend_reg && (q_cnt_reg != 2'd2 || pop);
    assign accept = in_ch.valid && in_ch.ready;
    assign is_start = accept && cmd_t'(in_ch.command) == CMD_START && !awaiting_reg;
    assign is_byte  = accept && cmd_t'(in_ch.command) == CMD_BYTE && awaiting_reg;
    assign is_tick  = accept && cmd_t'(in_ch.command) == CMD_TICK && awaiting_reg;
    assign is_read  = accept && cmd_t'(in_ch.command) == CMD_READ;

    crl_req_gen u_req (
        .clk, .rst_n,
        .start(is_start), .advance(rg_adv),
        .target(target_reg), .source(source_reg), .func(func_reg),
        .count(in_ch.count), .start_register(in_ch.start_register),
        .busy(rg_busy), .tx_byte(rg_byte), .tx_last(rg_last)
    );

    // frame byte handling
    logic [8:0]  p;
    logic [7:0]  b;
    logic [7:0]  hcrc_n;
    logic [15:0] pcrc_n, rcrc_n;
    logic        done;
    logic [2:0]  st;
    logic        tmo;
    assign p = pos_reg;
    assign b = in_ch.rx_byte;
    assign hcrc_n = (p < 9'd7) ? crc8_step(hcrc_reg, b) : hcrc_reg;
    assign pcrc_n = (p >= 9'd8 && p + 9'd2 < exp_len_reg) ? crc16_step(pcrc_reg, b) : pcrc_reg;
    assign rcrc_n = (p + 9'd2 >= exp_len_reg) ? {rcrc_reg[7:0], b} : rcrc_reg;
    assign done = !(p == 9'd0 && b != SYNC_BYTE) && (p + 9'd1 >= exp_len_reg);
    assign tmo  = tick_reg >= timeout_reg;
    always_comb
    begin
        if (!hcrc_ok_reg && p != 9'd7) st = ST_HDR_CRC;
        else if (p == 9'd7 && hcrc_reg != b) st = ST_HDR_CRC;
        else if (exp_len_reg != 9'd8 + {1'b0, (p == 9'd6) ? b : plen_reg}) st = ST_LENGTH;
        else if (rcrc_n != pcrc_n) st = ST_PAY_CRC;
        else st = ST_OK;
    end

    always_comb
    begin
        wr.en   = is_byte && !(p == 9'd0 && b != SYNC_BYTE) && p >= 9'd18
                  && (p - 9'd18) < 9'(DATA_DEPTH);
        wr.addr = DATA_AW'(p - 9'd18);
        wr.data = b;
    end

    // read address check, done in the accept cycle
    assign off  = in_ch.register_addr - fstart_reg;
    assign have = (exp_len_reg >= REQ_LEN) ? exp_len_reg - REQ_LEN : 9'd0;
    assign rd_ok = dvalid_reg && in_ch.register_addr >= fstart_reg
                   && ({1'b0, off} + 17'd1 < {9'd0, fdlen_reg})
                   && ({1'b0, off} + 17'd1 < {8'd0, have})
                   && ({1'b0, off} + 17'd1 < 17'(DATA_DEPTH));

    crl_data_ram u_ram (
        .clk, .wr,
        .rd_addr_a(DATA_AW'(off)), .rd_addr_b(DATA_AW'(off + 16'd1)),
        .rd_data_a(ra_data), .rd_data_b(rb_data)
    );

    // result push: request bytes, status, or delayed read answer
    assign rg_adv = rg_busy && (q_cnt_reg == 2'd0 || pop || q_cnt_reg == 2'd1);
    always_comb
    begin
        push     = 1'b0;
        push_res = '0;
        push_res.last = 1'b1;
        if (rd_pend_reg)
        begin
            push = 1'b1;
            push_res.kind = KIND_READ;
            push_res.word_valid = rd_ok_reg;
            push_res.word_value = rd_ok_reg ? {rb_data, ra_data} : 16'h0000;
        end
        else if (rg_adv)
        begin
            push = 1'b1;
            push_res.kind = KIND_TX;
            push_res.tx_byte = rg_byte;
            push_res.last = rg_last;
        end
        else if (is_byte && done)
        begin
            push = 1'b1;
            push_res.kind = KIND_STATUS;
            push_res.status = st;
        end
        else if (is_tick && tmo)
        begin
            push = 1'b1;
            push_res.kind = KIND_STATUS;
            push_res.status = ST_TIMEOUT;
        end
    end

    // queue
    assign out_ch.valid      = q_cnt_reg != 2'd0;
    assign out_ch.kind       = q_reg[q_rd_reg].kind;
    assign out_ch.tx_byte    = q_reg[q_rd_reg].tx_byte;
    assign out_ch.status     = q_reg[q_rd_reg].status;
    assign out_ch.word_value = q_reg[q_rd_reg].word_value;
    assign out_ch.word_valid = q_reg[q_rd_reg].word_valid;
    assign out_ch.last       = q_reg[q_rd_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            q_rd_reg  <= 1'b0;
            q_wr_reg  <= 1'b0;
        end
        else
        begin
            if (push) q_wr_reg <= !q_wr_reg;
            if (pop)  q_rd_reg <= !q_rd_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[q_wr_reg] <= push_res;
        rd_ok_reg <= rd_ok;
    end

    // frame state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            pos_reg      <= '0;
            exp_len_reg  <= '0;
            tick_reg     <= '0;
            hcrc_reg     <= '0;
            hcrc_ok_reg  <= 1'b0;
            plen_reg     <= '0;
            pcrc_reg     <= '0;
            rcrc_reg     <= '0;
            fdlen_reg    <= '0;
            fstart_reg   <= '0;
            dvalid_reg   <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= is_read;
            if (is_start)
            begin
                awaiting_reg <= 1'b1;
                pos_reg      <= '0;
                exp_len_reg  <= REQ_LEN + {1'b0, in_ch.count};
                tick_reg     <= '0;
                hcrc_reg     <= '0;
                hcrc_ok_reg  <= 1'b0;
                plen_reg     <= '0;
                pcrc_reg     <= '0;
                rcrc_reg     <= '0;
                dvalid_reg   <= 1'b0;
            end
            else if (is_byte && !(p == 9'd0 && b != SYNC_BYTE))
            begin
                hcrc_reg <= hcrc_n;
                pcrc_reg <= pcrc_n;
                rcrc_reg <= rcrc_n;
                if (p == 9'd6) plen_reg <= b;
                if (p == 9'd7) hcrc_ok_reg <= (hcrc_reg == b);
                if (p == 9'd15) fdlen_reg <= b;
                if (p == 9'd16) fstart_reg[7:0] <= b;
                if (p == 9'd17) fstart_reg[15:8] <= b;
                pos_reg <= p + 9'd1;
                if (done)
                begin
                    awaiting_reg <= 1'b0;
                    dvalid_reg   <= (st == ST_OK);
                end
            end
            else if (is_tick)
            begin
                if (tmo) awaiting_reg <= 1'b0;
                else     tick_reg <= tick_reg + 16'd1;
            end
        end
    end

    `CRL_ASSERT_IMP(a_no_overflow, clk, rst_n, q_cnt_reg == 2'd2, !push || pop,
        "result queue overflow")
    `CRL_ASSERT_NEXT(a_read_answer, clk, rst_n, is_read, push && !rg_adv,
        "read answer not pushed next cycle")
    `CRL_ASSERT_IMP(a_no_accept_tx, clk, rst_n, rg_busy, !accept,
        "item accepted while request streams")
endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the register read link. A built-in model predicts
// every transfer: request bytes, frame status and register read answers.
// Both sides idle and stall at random. The receiver also holds off once for
// a long stretch, and the sender pauses before each configuration change and
// twice more until the output is drained.
module testbench;
    import crl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int ITEM_TARGET  = 210;

    // ------------------------------------------------------------------------
    // Link model and result checker
    // ------------------------------------------------------------------------
    class link_scoreboard;
        // register file
        bit [7:0]  tgt, src, func;
        bit [15:0] tmo;
        // receive state
        bit        awaiting, hdr_ok, store_ok;
        bit [8:0]  pos, want_len;
        bit [15:0] ticks, pay_crc, got_crc, frame_reg;
        bit [7:0]  hdr_crc, pay_len, frame_dlen;
        bit [7:0]  store[DATA_DEPTH];
        result_t   waiting[$];
        int        errors, n_status[5], n_word_ok, n_word_bad, n_tx;

        function new();
            tgt = 0; src = 0; func = FUNC_RST; tmo = TIMEOUT_RST;
            awaiting = 0; hdr_ok = 0; store_ok = 0; pos = 0; want_len = 0;
            ticks = 0; pay_crc = 0; got_crc = 0; frame_reg = 0;
            hdr_crc = 0; pay_len = 0; frame_dlen = 0;
        endfunction

        static function bit [7:0] crc8(bit [7:0] crc, bit [7:0] b);
            bit fb;
            for (int i = 7; i >= 0; i--) begin
                fb = crc[7] ^ b[i];
                crc = {crc[6:0], 1'b0};
                if (fb) crc = crc ^ 8'hD5;
            end
            return crc;
        endfunction

        static function bit [15:0] crc16(bit [15:0] crc, bit [7:0] b);
            bit fb;
            for (int i = 7; i >= 0; i--) begin
                fb = crc[15] ^ b[i];
                crc = {crc[14:0], 1'b0};
                if (fb) crc = crc ^ 16'h1021;
            end
            return crc;
        endfunction

        function void write_reg(reg_idx_t idx, bit [15:0] val);
            case (idx)
                REG_TARGET:  tgt  = val[7:0];
                REG_SOURCE:  src  = val[7:0];
                REG_FUNC:    func = val[7:0];
                REG_TIMEOUT: tmo  = val;
            endcase
        endfunction

        function void push(kind_t k, bit [7:0] tx, status_t st, bit [15:0] w, bit wv,
                           bit lst);
            result_t r;
            r.kind = k; r.tx_byte = tx; r.status = st;
            r.word_value = w; r.word_valid = wv; r.last = lst;
            waiting.insert(waiting.size(), r);
        endfunction

        // Accepted input item: update state, queue what it should produce.
        function void note_item(cmd_t c, bit [15:0] sreg, bit [7:0] cnt, bit [7:0] rb,
                                bit [15:0] ra);
            bit [7:0]  req[20];
            bit [7:0]  c8;
            bit [15:0] c16;
            int        p, off, have;
            status_t   st;
            case (c)
                CMD_START: if (!awaiting) begin
                    req = '{SYNC_BYTE, tgt, src, HDR_CTRL, 8'h00, 8'h00, HDR_LEN, 8'h00,
                            tgt, 8'h00, src, 8'h00, func, SOFT_CTRL, 8'h00, cnt,
                            sreg[7:0], sreg[15:8], 8'h00, 8'h00};
                    c8 = 0;
                    for (int i = 0; i < 7; i++) c8 = crc8(c8, req[i]);
                    req[7] = c8;
                    c16 = 0;
                    for (int i = 8; i < 18; i++) c16 = crc16(c16, req[i]);
                    req[18] = c16[15:8];
                    req[19] = c16[7:0];
                    for (int i = 0; i < 20; i++)
                        push(KIND_TX, req[i], ST_OK, 16'h0000, 1'b0, i == 19);
                    awaiting = 1; pos = 0; want_len = 9'd20 + {1'b0, cnt}; ticks = 0;
                    hdr_crc = 0; hdr_ok = 0; pay_len = 0; pay_crc = 0; got_crc = 0;
                    store_ok = 0;
                end
                CMD_BYTE: if (awaiting && !(pos == 0 && rb != SYNC_BYTE)) begin
                    p = pos;
                    if (p < 7)  hdr_crc = crc8(hdr_crc, rb);
                    if (p == 6) pay_len = rb;
                    if (p == 7) hdr_ok = (hdr_crc == rb);
                    if (p == 15) frame_dlen = rb;
                    if (p == 16) frame_reg[7:0]  = rb;
                    if (p == 17) frame_reg[15:8] = rb;
                    if (p >= 8 && p + 2 < want_len) pay_crc = crc16(pay_crc, rb);
                    if (p + 2 >= want_len) got_crc = {got_crc[7:0], rb};
                    if (p >= 18 && p - 18 < DATA_DEPTH) store[p - 18] = rb;
                    pos = pos + 9'd1;
                    if (p + 1 >= want_len) begin
                        if (!hdr_ok)                                st = ST_HDR_CRC;
                        else if (want_len != 9'd8 + {1'b0, pay_len}) st = ST_LENGTH;
                        else if (got_crc != pay_crc)                st = ST_PAY_CRC;
                        else                                        st = ST_OK;
                        store_ok = (st == ST_OK);
                        awaiting = 0;
                        push(KIND_STATUS, 8'h00, st, 16'h0000, 1'b0, 1'b1);
                    end
                end
                CMD_TICK: if (awaiting) begin
                    if (ticks >= tmo) begin
                        awaiting = 0;
                        push(KIND_STATUS, 8'h00, ST_TIMEOUT, 16'h0000, 1'b0, 1'b1);
                    end else
                        ticks++;
                end
                CMD_READ: begin
                    off  = int'(ra) - int'(frame_reg);
                    have = (want_len >= 20) ? want_len - 20 : 0;
                    if (store_ok && off >= 0 && off + 1 < frame_dlen && off + 1 < have
                        && off + 1 < DATA_DEPTH)
                        push(KIND_READ, 8'h00, ST_OK, {store[off + 1], store[off]}, 1'b1,
                             1'b1);
                    else
                        push(KIND_READ, 8'h00, ST_OK, 16'h0000, 1'b0, 1'b1);
                end
            endcase
        endfunction

        function void field(string nm, logic [15:0] e, logic [15:0] a);
            if (a !== e) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, e, a);
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (waiting.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, actual %p", $time, got);
                return;
            end
            e = waiting.pop_front();
            field("kind", 16'(e.kind), 16'(got.kind));
            field("tx_byte", 16'(e.tx_byte), 16'(got.tx_byte));
            field("status", 16'(e.status), 16'(got.status));
            field("word_value", e.word_value, got.word_value);
            field("word_valid", 16'(e.word_valid), 16'(got.word_valid));
            field("last", 16'(e.last), 16'(got.last));
            case (e.kind)
                KIND_TX:     n_tx++;
                KIND_STATUS: n_status[e.status]++;
                default:     if (e.word_valid) n_word_ok++; else n_word_bad++;
            endcase
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    crl_in_if  in_ch();
    crl_out_if out_ch();
    crl_cfg_if cfg();

    crc_checked_register_read_link u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    link_scoreboard sb = new();
    int             items_sent;
    int             burst_left;
    bit             hold_req;
    bit [7:0]       frame_bytes[$];

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t: cycle limit reached, %0d results outstanding",
                         $time, sb.waiting.size());
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Output monitor: sample at the rising edge, before the DUT updates.
    initial
    begin
        result_t r;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                r.kind = out_ch.kind; r.tx_byte = out_ch.tx_byte;
                r.status = out_ch.status; r.word_value = out_ch.word_value;
                r.word_valid = out_ch.word_valid; r.last = out_ch.last;
                sb.check_result(r);
            end
        end
    end

    // Receiver: alternating stretches of full rate, light and heavy stalls.
    // A hold request forces ready low for a long run of cycles so the output
    // queue fills and the input side backs up.
    initial
    begin
        int hold, mode, span;
        bit hold_used;
        hold = 0; mode = 0; span = 0; hold_used = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_used)
            begin
                hold = 300;
                hold_used = 1;
            end
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(10, 60);
                end
                span--;
                out_ch.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 2) >= mode);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One input transfer. The sender runs in bursts; between bursts valid
    // drops for a random gap. Inputs change only on the falling edge.
    task automatic send_item(cmd_t c, bit [15:0] sreg, bit [7:0] cnt, bit [7:0] rb,
                             bit [15:0] ra);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid          <= 1'b1;
        in_ch.command        <= c;
        in_ch.start_register <= sreg;
        in_ch.count          <= cnt;
        in_ch.rx_byte        <= rb;
        in_ch.register_addr  <= ra;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(c, sreg, cnt, rb, ra);
        items_sent++;
    endtask

    task automatic send_start(bit [15:0] sreg, bit [7:0] cnt);
        send_item(CMD_START, sreg, cnt, 8'($urandom), 16'($urandom));
    endtask

    task automatic send_byte(bit [7:0] b);
        send_item(CMD_BYTE, 16'($urandom), 8'($urandom), b, 16'($urandom));
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic send_read(bit [15:0] ra);
        send_item(CMD_READ, 16'($urandom), 8'($urandom), 8'($urandom), ra);
    endtask

    // Drop valid, wait for every expected transfer, then let the pipeline
    // settle (bytes and ticks may still be in flight without a result).
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.waiting.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, bit [15:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_config(bit [7:0] t, bit [7:0] s, bit [7:0] f, bit [15:0] to);
        drain();
        write_reg(REG_TARGET, {8'h00, t});
        write_reg(REG_SOURCE, {8'h00, s});
        write_reg(REG_FUNC, {8'h00, f});
        write_reg(REG_TIMEOUT, to);
    endtask

    function automatic void add_frame_byte(bit [7:0] v);
        frame_bytes.insert(frame_bytes.size(), v);
    endfunction

    // Response frame for cnt data bytes. flaw selects the defect:
    // 0 none, 1 header CRC, 2 length byte, 3 payload CRC (4 is handled by
    // the caller as a truncated frame).
    function automatic void build_frame(int cnt, int flaw, bit [15:0] sreg,
                                        bit [7:0] dlen);
        bit [7:0]  c8;
        bit [15:0] c16;
        frame_bytes.delete();
        add_frame_byte(SYNC_BYTE);
        repeat (5) add_frame_byte(8'($urandom));
        add_frame_byte((flaw == 2) ? 8'(12 + cnt + $urandom_range(1, 255))
                                   : 8'(12 + cnt));
        c8 = 0;
        for (int i = 0; i < 7; i++) c8 = link_scoreboard::crc8(c8, frame_bytes[i]);
        if (flaw == 1) c8 ^= 8'(1 << $urandom_range(0, 7));
        add_frame_byte(c8);
        repeat (7) add_frame_byte(8'($urandom));
        add_frame_byte(dlen);
        add_frame_byte(sreg[7:0]);
        add_frame_byte(sreg[15:8]);
        repeat (cnt) add_frame_byte(8'($urandom));
        c16 = 0;
        for (int i = 8; i < frame_bytes.size(); i++)
            c16 = link_scoreboard::crc16(c16, frame_bytes[i]);
        if (flaw == 3) c16 ^= 16'($urandom_range(1, 65535));
        add_frame_byte(c16[15:8]);
        add_frame_byte(c16[7:0]);
    endfunction

    // Full request/response exchange followed by a few register reads.
    task automatic exchange(int cnt, int flaw, bit [15:0] sreg);
        bit [7:0] noise;
        bit [7:0] dlen;
        int       n;
        send_start(sreg, 8'(cnt));
        // junk ahead of the sync byte must be skipped
        repeat ($urandom_range(0, 3))
        begin
            noise = 8'($urandom);
            if (noise == SYNC_BYTE) noise = 8'h96;
            send_byte(noise);
        end
        dlen = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(cnt);
        build_frame(cnt, flaw, sreg, dlen);
        n = (flaw == 4) ? $urandom_range(0, frame_bytes.size() - 1) : frame_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0) send_tick();
            send_byte(frame_bytes[i]);
        end
        if (flaw == 4)
            repeat (int'(sb.tmo) + 1) send_tick();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 5) == 0) send_read(16'($urandom));
            else send_read(sreg + 16'($urandom_range(0, cnt + 2)));
        end
    endtask

    task automatic random_exchanges(int upto);
        int flaw, cnt;
        while (items_sent < upto)
        begin
            flaw = $urandom_range(0, 9);
            if (flaw > 4) flaw = 0;
            if (flaw == 4 && sb.tmo > 64) flaw = 0;
            cnt = ($urandom_range(0, 11) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(0, 12);
            exchange(cnt, flaw, 16'($urandom));
            // stray noise between exchanges
            if ($urandom_range(0, 3) == 0) send_byte(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 0;
        hold_req = 0;
        items_sent = 0;
        burst_left = 0;
        in_ch.valid = 0; in_ch.command = CMD_START; in_ch.start_register = 0;
        in_ch.count = 0; in_ch.rx_byte = 0; in_ch.register_addr = 0;
        cfg.valid = 0; cfg.index = REG_TARGET; cfg.data = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: idle items are ignored, reads before any good frame fail.
        send_byte(SYNC_BYTE);
        send_tick();
        send_read(16'h0000);
        // good frame of four data bytes with junk first and a second start
        // issued mid-frame, which must be ignored
        send_start(16'h1234, 8'd4);
        send_byte(8'h00);
        send_byte(8'hFF);
        build_frame(4, 0, 16'h1234, 8'd4);
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            if (i == 3) send_start(16'hFFFF, 8'hFF);
            send_byte(frame_bytes[i]);
        end
        // in range, last word, one past the data, below the base, far away
        send_read(16'h1234);
        send_read(16'h1236);
        send_read(16'h1237);
        send_read(16'h1233);
        send_read(16'hFFFF);
        // header CRC, length and payload CRC defects on an empty frame
        exchange(0, 1, 16'h0000);
        exchange(0, 2, 16'hFFFF);
        exchange(0, 3, 16'h8001);

        // Extremes with the shortest timeout; long receiver hold during a
        // request so the output fills and the input backs up.
        set_config(8'hFF, 8'hFF, 8'h00, 16'd1);
        hold_req = 1;
        exchange(2, 4, 16'hABCD);
        // full count field in the request, then a timeout
        send_start(16'h0F0F, 8'hFF);
        send_byte(SYNC_BYTE);
        repeat (int'(sb.tmo) + 1) send_tick();
        random_exchanges(140);

        // Sender pause: everything expected arrives before going on.
        drain();
        random_exchanges(160);

        set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(2, 40)));
        random_exchanges(185);

        // Longest timeout to close out the run.
        set_config(8'h00, 8'h00, 8'hFF, 16'hFFFF);
        random_exchanges(ITEM_TARGET);

        drain();
        $display("covered %0d input items: %0d request bytes, status ok/hdr/len/pay/tmo "
                 , items_sent, sb.n_tx);
        $display("  %0d/%0d/%0d/%0d/%0d, reads %0d valid %0d invalid",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3],
                 sb.n_status[4], sb.n_word_ok, sb.n_word_bad);
        if (sb.errors == 0 && sb.waiting.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
